/* hw/rtl/msb_pkg.sv */
// shared types, codes and helpers of the masked sprite blitter
package msb_pkg;

	localparam int WORD_W             = 16;
	localparam int SPR_WORDS_PER_ROW  = 4;
	localparam int DRAW_SPAN          = 5;
	localparam int FB_ADDR_W          = 13;

	localparam int SPRITE_SLOTS_DEF     = 64;
	localparam int SPRITE_ROWS_DEF      = 64;
	localparam int FB_WORDS_PER_ROW_DEF = 32;
	localparam int FB_ROWS_DEF          = 256;

	localparam logic [1:0] OP_LOAD  = 2'd0;
	localparam logic [1:0] OP_CLEAR = 2'd1;
	localparam logic [1:0] OP_DRAW  = 2'd2;
	localparam logic [1:0] OP_READ  = 2'd3;

	typedef struct packed {
		logic [1:0]           op;
		logic [5:0]           sprite_index;
		logic [5:0]           sprite_row;
		logic [1:0]           sprite_word;
		logic [WORD_W-1:0]    color_word;
		logic [WORD_W-1:0]    alpha_word;
		logic [8:0]           pos_x;
		logic [7:0]           pos_y;
		logic                 fill_white;
		logic [FB_ADDR_W-1:0] fb_address;
	} req_t;

	typedef struct packed {
		logic [WORD_W-1:0]    read_data;
		logic [FB_ADDR_W-1:0] read_address;
	} rsp_t;

	// memory strobes from the engine
	typedef struct packed {
		logic                         spr_re;
		logic [SPR_WORDS_PER_ROW-1:0] spr_we;
		logic                         fb_re;
		logic                         fb_we;
	} mem_ctl_t;

	// read completion handed to the output register
	typedef struct packed {
		logic                 load;
		logic                 in_range;
		logic [FB_ADDR_W-1:0] address;
	} rd_status_t;

	// right shift of a word with the bits of its left neighbor shifted in
	function automatic logic [WORD_W-1:0] shift_pair(input logic [WORD_W-1:0] prev,
		input logic [WORD_W-1:0] cur, input logic [3:0] s);
		logic [2*WORD_W-1:0] pair;
		pair = {prev, cur} >> s;
		return pair[WORD_W-1:0];
	endfunction

endpackage

/* hw/rtl/msb_ram.sv */
// generic simple dual-port ram with registered read
module msb_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 1024
) (
	input  logic                                      clk,
	input  logic                                      we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                          wdata,
	input  logic                                      re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                          rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

/* hw/rtl/msb_engine.sv */
// request sequencer: load, clear sweep, draw read-modify-write and read
module msb_engine #(
	parameter int SPRITE_SLOTS     = msb_pkg::SPRITE_SLOTS_DEF,
	parameter int SPRITE_ROWS      = msb_pkg::SPRITE_ROWS_DEF,
	parameter int FB_WORDS_PER_ROW = msb_pkg::FB_WORDS_PER_ROW_DEF,
	parameter int FB_ROWS          = msb_pkg::FB_ROWS_DEF,
	localparam int SPR_DEPTH       = SPRITE_SLOTS * SPRITE_ROWS,
	localparam int SPR_AW          = (SPR_DEPTH > 1) ? $clog2(SPR_DEPTH) : 1,
	localparam int FB_WORDS        = FB_WORDS_PER_ROW * FB_ROWS,
	localparam int FB_AW           = (FB_WORDS > 1) ? $clog2(FB_WORDS) : 1
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    req_valid,
	output logic                    req_stall,
	input  msb_pkg::req_t           req,
	input  logic                    slot_free,
	output msb_pkg::rd_status_t     rd_status,
	output msb_pkg::mem_ctl_t       mem_ctl,
	output logic [SPR_AW-1:0]       spr_waddr,
	output logic [2*msb_pkg::WORD_W-1:0] spr_wdata,
	output logic [SPR_AW-1:0]       spr_raddr,
	input  logic [msb_pkg::SPR_WORDS_PER_ROW-1:0][2*msb_pkg::WORD_W-1:0] spr_rdata,
	output logic [FB_AW-1:0]        fb_waddr,
	output logic [msb_pkg::WORD_W-1:0] fb_wdata,
	output logic [FB_AW-1:0]        fb_raddr,
	input  logic [msb_pkg::WORD_W-1:0] fb_rdata
);
	import msb_pkg::*;

	// wide enough for any draw address, any read address and the buffer size
	localparam int LIN_W = $clog2((256 + SPRITE_ROWS) * FB_WORDS_PER_ROW + FB_WORDS + 8192);
	localparam int ROW_W = (SPRITE_ROWS > 1) ? $clog2(SPRITE_ROWS) : 1;

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_CLEAR = 3'd1;
	localparam logic [2:0] ST_SPR   = 3'd2;
	localparam logic [2:0] ST_FB    = 3'd3;
	localparam logic [2:0] ST_DRAIN = 3'd4;
	localparam logic [2:0] ST_READ  = 3'd5;

	logic [2:0]           state_q;
	logic [SPR_AW-1:0]    spr_addr_q;
	logic [ROW_W-1:0]     row_q;
	logic [2:0]           phase_q;
	logic [LIN_W-1:0]     rowbase_q;
	logic [3:0]           shift_q;
	logic [FB_AW-1:0]     clr_addr_q;
	logic                 fill_q;
	logic [FB_ADDR_W-1:0] rd_addr_q;
	logic                 rd_inb_q;

	logic                 wr_valid_s1;
	logic                 wr_inb_s1;
	logic [FB_AW-1:0]     wr_addr_s1;
	logic [2:0]           m_s1;

	logic                 take;
	logic                 slot_ok;
	logic                 row_ok;
	logic [LIN_W-1:0]     lin;
	logic [LIN_W-1:0]     lin_rd;
	logic                 lin_inb;
	logic [2:0]           m_prev;
	logic [WORD_W-1:0]    c_cur, c_prev, a_cur, a_prev;
	logic [WORD_W-1:0]    c_sh, a_sh;

	assign req_stall = (state_q != ST_IDLE);
	assign take      = req_valid && !req_stall;
	assign slot_ok   = (32'(req.sprite_index) < SPRITE_SLOTS);
	assign row_ok    = (32'(req.sprite_row) < SPRITE_ROWS);
	assign lin       = rowbase_q + LIN_W'(phase_q);
	assign lin_inb   = (lin < LIN_W'(FB_WORDS));
	assign lin_rd    = LIN_W'(req.fb_address);

	// sprite load goes straight into the addressed bank
	assign spr_waddr = SPR_AW'(32'(req.sprite_index) * SPRITE_ROWS + 32'(req.sprite_row));
	assign spr_wdata = {req.color_word, req.alpha_word};
	assign spr_raddr = spr_addr_q;

	always_comb begin
		mem_ctl        = '0;
		mem_ctl.spr_re = (state_q == ST_SPR);
		if (take && req.op == OP_LOAD && slot_ok && row_ok) begin
			mem_ctl.spr_we[req.sprite_word] = 1'b1;
		end
		mem_ctl.fb_re = (state_q == ST_FB) || (take && req.op == OP_READ);
		mem_ctl.fb_we = (state_q == ST_CLEAR) || (wr_valid_s1 && wr_inb_s1);
	end

	always_comb begin
		if (state_q == ST_FB) begin
			fb_raddr = lin[FB_AW-1:0];
		end else begin
			fb_raddr = lin_rd[FB_AW-1:0];
		end
	end

	// merge stage: shifted sprite word over the old framebuffer word
	assign m_prev = m_s1 - 3'd1;
	always_comb begin
		c_cur  = '0;
		a_cur  = '0;
		c_prev = '0;
		a_prev = '0;
		if (!m_s1[2]) begin
			c_cur = spr_rdata[m_s1[1:0]][2*WORD_W-1:WORD_W];
			a_cur = spr_rdata[m_s1[1:0]][WORD_W-1:0];
		end
		if (m_s1 != 3'd0) begin
			c_prev = spr_rdata[m_prev[1:0]][2*WORD_W-1:WORD_W];
			a_prev = spr_rdata[m_prev[1:0]][WORD_W-1:0];
		end
	end
	assign c_sh = shift_pair(c_prev, c_cur, shift_q);
	assign a_sh = shift_pair(a_prev, a_cur, shift_q);

	always_comb begin
		if (state_q == ST_CLEAR) begin
			fb_waddr = clr_addr_q;
			fb_wdata = {WORD_W{fill_q}};
		end else begin
			fb_waddr = wr_addr_s1;
			fb_wdata = (c_sh & a_sh) | (fb_rdata & ~a_sh);
		end
	end

	assign rd_status.load     = (state_q == ST_READ) && slot_free;
	assign rd_status.in_range = rd_inb_q;
	assign rd_status.address  = rd_addr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			wr_valid_s1 <= 1'b0;
		end else begin
			wr_valid_s1 <= (state_q == ST_FB);
			case (state_q)
				ST_IDLE: begin
					if (take) begin
						case (req.op)
							OP_CLEAR: state_q <= ST_CLEAR;
							OP_DRAW: begin
								if (slot_ok) begin
									state_q <= ST_SPR;
								end
							end
							OP_READ: state_q <= ST_READ;
							default: state_q <= ST_IDLE;
						endcase
					end
				end
				ST_CLEAR: begin
					if (clr_addr_q == FB_AW'(FB_WORDS - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_SPR: state_q <= ST_FB;
				ST_FB: begin
					if (phase_q == 3'(DRAW_SPAN - 1)) begin
						if (row_q == ROW_W'(SPRITE_ROWS - 1)) begin
							state_q <= ST_DRAIN;
						end else begin
							state_q <= ST_SPR;
						end
					end
				end
				ST_DRAIN: state_q <= ST_IDLE;
				ST_READ: begin
					if (slot_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		wr_addr_s1 <= lin[FB_AW-1:0];
		wr_inb_s1  <= lin_inb;
		m_s1       <= phase_q;
		case (state_q)
			ST_IDLE: begin
				clr_addr_q <= '0;
				fill_q     <= req.fill_white;
				spr_addr_q <= SPR_AW'(32'(req.sprite_index) * SPRITE_ROWS);
				row_q      <= '0;
				phase_q    <= '0;
				rowbase_q  <= LIN_W'(32'(req.pos_y) * FB_WORDS_PER_ROW + 32'(req.pos_x[8:4]));
				shift_q    <= req.pos_x[3:0];
				rd_addr_q  <= req.fb_address;
				rd_inb_q   <= (lin_rd < LIN_W'(FB_WORDS));
			end
			ST_CLEAR: clr_addr_q <= clr_addr_q + FB_AW'(1);
			ST_SPR: phase_q <= '0;
			ST_FB: begin
				if (phase_q == 3'(DRAW_SPAN - 1)) begin
					row_q      <= row_q + ROW_W'(1);
					spr_addr_q <= spr_addr_q + SPR_AW'(1);
					rowbase_q  <= rowbase_q + LIN_W'(FB_WORDS_PER_ROW);
				end else begin
					phase_q <= phase_q + 3'd1;
				end
			end
			default: begin
			end
		endcase
	end

endmodule

/* hw/rtl/masked_sprite_blitter_unit.sv */
// top level of the masked sprite blitter: memories, engine and result register
//
//   channel  dir  handshake               payload
//   req      in   req_valid / req_stall   msb_pkg::req_t (load, clear, draw, read)
//   rsp      out  rsp_valid / rsp_stall   msb_pkg::rsp_t (read_data, read_address)
//
// load is written in the cycle it is taken; read passes the frame memory read register
// and then the result register, later if that is stalled; clear sweeps the frame memory
// one word a cycle; draw does per sprite row one read of the four sprite banks,
// then five pipelined read-modify-writes through the single frame memory port pair
// arst_n clears control state only; memory contents are undefined until loaded or cleared
// a waiting result does not block loads, clears or draws; only a second read waits for it
module masked_sprite_blitter_unit #(
	parameter int SPRITE_SLOTS     = msb_pkg::SPRITE_SLOTS_DEF,
	parameter int SPRITE_ROWS      = msb_pkg::SPRITE_ROWS_DEF,
	parameter int FB_WORDS_PER_ROW = msb_pkg::FB_WORDS_PER_ROW_DEF,
	parameter int FB_ROWS          = msb_pkg::FB_ROWS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_stall,
	input  msb_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_stall,
	output msb_pkg::rsp_t rsp
);
	import msb_pkg::*;

	localparam int SPR_DEPTH = SPRITE_SLOTS * SPRITE_ROWS;
	localparam int SPR_AW    = (SPR_DEPTH > 1) ? $clog2(SPR_DEPTH) : 1;
	localparam int FB_WORDS  = FB_WORDS_PER_ROW * FB_ROWS;
	localparam int FB_AW     = (FB_WORDS > 1) ? $clog2(FB_WORDS) : 1;

	// engine side
	mem_ctl_t          mem_ctl;
	rd_status_t        rd_status;
	logic [SPR_AW-1:0] spr_waddr;
	logic [SPR_AW-1:0] spr_raddr;
	logic [2*WORD_W-1:0] spr_wdata;
	logic [SPR_WORDS_PER_ROW-1:0][2*WORD_W-1:0] spr_rdata;
	logic [FB_AW-1:0]  fb_waddr;
	logic [FB_AW-1:0]  fb_raddr;
	logic [WORD_W-1:0] fb_wdata;
	logic [WORD_W-1:0] fb_rdata;

	// result register
	logic rsp_valid_q;
	rsp_t rsp_q;
	logic slot_free;

	// slot is free when empty or when the held result leaves this cycle
	assign slot_free = !rsp_valid_q || !rsp_stall;

	msb_engine #(
		.SPRITE_SLOTS     (SPRITE_SLOTS),
		.SPRITE_ROWS      (SPRITE_ROWS),
		.FB_WORDS_PER_ROW (FB_WORDS_PER_ROW),
		.FB_ROWS          (FB_ROWS)
	) u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.slot_free (slot_free),
		.rd_status (rd_status),
		.mem_ctl   (mem_ctl),
		.spr_waddr (spr_waddr),
		.spr_wdata (spr_wdata),
		.spr_raddr (spr_raddr),
		.spr_rdata (spr_rdata),
		.fb_waddr  (fb_waddr),
		.fb_wdata  (fb_wdata),
		.fb_raddr  (fb_raddr),
		.fb_rdata  (fb_rdata)
	);

	// one bank per 16-pixel word of a sprite row, color in the upper half, alpha in the lower
	for (genvar b = 0; b < SPR_WORDS_PER_ROW; b++) begin : g_spr_bank
		msb_ram #(
			.WIDTH (2 * WORD_W),
			.DEPTH (SPR_DEPTH)
		) u_spr_ram (
			.clk   (clk),
			.we    (mem_ctl.spr_we[b]),
			.waddr (spr_waddr),
			.wdata (spr_wdata),
			.re    (mem_ctl.spr_re),
			.raddr (spr_raddr),
			.rdata (spr_rdata[b])
		);
	end

	// linear frame memory
	msb_ram #(
		.WIDTH (WORD_W),
		.DEPTH (FB_WORDS)
	) u_fb_ram (
		.clk   (clk),
		.we    (mem_ctl.fb_we),
		.waddr (fb_waddr),
		.wdata (fb_wdata),
		.re    (mem_ctl.fb_re),
		.raddr (fb_raddr),
		.rdata (fb_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (rd_status.load) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	// reads beyond the buffer return zero
	always_ff @(posedge clk) begin
		if (rd_status.load) begin
			rsp_q.read_data    <= rd_status.in_range ? fb_rdata : '0;
			rsp_q.read_address <= rd_status.address;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

`ifndef SYNTHESIS
	// a new read result never lands on a held, stalled one
	assert property (@(posedge clk) disable iff (!arst_n)
		rd_status.load |-> (!rsp_valid_q || !rsp_stall))
		else $error("read result overwrote a stalled response");

	// the draw pipeline has drained before the next request is taken
	assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && !req_stall) |-> !mem_ctl.fb_we)
		else $error("frame write still pending at request accept");

	// a load writes at most one sprite bank
	assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(mem_ctl.spr_we))
		else $error("more than one sprite bank written");

	// read-modify-write never reads the word it is writing
	assert property (@(posedge clk) disable iff (!arst_n)
		(mem_ctl.fb_re && mem_ctl.fb_we) |-> (fb_raddr != fb_waddr))
		else $error("frame read and write collide on one address");
`endif

endmodule
